// File: hdl/intel_hex_record_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked checks with and without reset qualification; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_DECODER_UNIT_ASSERT_SVH
`define INTEL_HEX_RECORD_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define IHEXD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define IHEXD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define IHEXD_ASSERT(lbl, prop, msg)

`define IHEXD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: hdl/ihexd_pkg.sv
// ----------------------------------------------------------------------------
// Intel HEX record decoder package
// Shared types and constants for the front end, token queue and back end.
// ----------------------------------------------------------------------------
package ihexd_pkg;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam logic [8:0] INDEX_MAX = 9'd511;
    localparam logic [8:0] HDR_BYTES = 9'd4;
    localparam logic [8:0] IDX_COUNT = 9'd0;
    localparam logic [8:0] IDX_ADDRH = 9'd1;
    localparam logic [8:0] IDX_ADDRL = 9'd2;
    localparam logic [8:0] IDX_KIND  = 9'd3;
    localparam logic [7:0] KIND_DATA = 8'h00;

    typedef enum logic [1:0] {
        TK_NEWLINE,
        TK_COLON,
        TK_DATA
    } token_kind_t;

    typedef struct packed {
        token_kind_t kind;
        logic [3:0]  nibble;
    } token_t;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_RECORD,
        PH_SKIP
    } phase_t;

endpackage

// File: hdl/ihexd_channels.sv
// ----------------------------------------------------------------------------
// Intel HEX record decoder channels
// Valid/ready interfaces for the character input and the write output.
// ----------------------------------------------------------------------------
interface ihexd_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

interface ihexd_write_if;
    logic        valid;
    logic        ready;
    logic [16:0] write_addr;
    logic [7:0]  write_data;

    modport source (output valid, output write_addr, output write_data, input ready);
    modport sink (input valid, input write_addr, input write_data, output ready);
endinterface

// File: hdl/ihexd_front.sv
// ----------------------------------------------------------------------------
// Intel HEX character classifier
// Accepts characters, drops whitespace, and queues newline, colon and data
// tokens; 0-9 and A-F carry their nibble value, other characters zero.
// ----------------------------------------------------------------------------
module ihexd_front (
    ihexd_char_if.sink      chars,
    input  logic            full,
    output logic            push,
    output ihexd_pkg::token_t push_tok
);

    logic blank;

    always_comb
    begin
        blank = chars.char_in inside {8'd9, 8'd11, 8'd12, 8'd13, 8'd32};
        push_tok.nibble = 4'd0;
        if (chars.char_in == ihexd_pkg::CHAR_NL)
        begin
            push_tok.kind = ihexd_pkg::TK_NEWLINE;
        end
        else if (chars.char_in == ihexd_pkg::CHAR_COLON)
        begin
            push_tok.kind = ihexd_pkg::TK_COLON;
        end
        else
        begin
            push_tok.kind = ihexd_pkg::TK_DATA;
            if (chars.char_in inside {[8'h30:8'h39]})
            begin
                push_tok.nibble = chars.char_in[3:0];
            end
            else if (chars.char_in inside {[8'h41:8'h46]})
            begin
                push_tok.nibble = chars.char_in[3:0] + 4'd9;
            end
        end
    end

    assign chars.ready = !full;
    assign push        = chars.valid && !full && !blank;

endmodule

// File: hdl/ihexd_token_fifo.sv
// ----------------------------------------------------------------------------
// Intel HEX token queue
// Short register queue between the classifier and the record engine.
// ----------------------------------------------------------------------------
module ihexd_token_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ihexd_pkg::token_t push_tok,
    output logic              full,
    input  logic              pop,
    output ihexd_pkg::token_t pop_tok,
    output logic              not_empty
);

    ihexd_pkg::token_t                   mem_reg [ihexd_pkg::FIFO_DEPTH];
    logic [ihexd_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [ihexd_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [ihexd_pkg::FIFO_CNT_W-1:0]    count_reg, count_next;
    logic                                do_push, do_pop;

    localparam logic [ihexd_pkg::FIFO_PTR_W-1:0] PTR_LAST =
        ihexd_pkg::FIFO_PTR_W'(ihexd_pkg::FIFO_DEPTH - 1);
    localparam logic [ihexd_pkg::FIFO_CNT_W-1:0] CNT_FULL =
        ihexd_pkg::FIFO_CNT_W'(ihexd_pkg::FIFO_DEPTH);

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_tok   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

// File: hdl/ihexd_back.sv
// ----------------------------------------------------------------------------
// Intel HEX record engine
// Pairs digits into bytes, tracks the record header and emits data writes
// through an output register.
// ----------------------------------------------------------------------------
`include "intel_hex_record_decoder_unit_assert.svh"

module ihexd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tok_valid,
    input  ihexd_pkg::token_t  tok,
    output logic               tok_pop,
    ihexd_write_if.source      writes
);

    ihexd_pkg::phase_t phase_reg, phase_next;
    logic              have_reg, have_next;
    logic [3:0]        high_reg, high_next;
    logic [8:0]        index_reg, index_next;
    logic [7:0]        length_reg, length_next;
    logic [15:0]       address_reg, address_next;
    logic [7:0]        kind_reg, kind_next;
    logic              out_valid_reg, out_valid_next;
    logic [16:0]       out_addr_reg, out_addr_next;
    logic [7:0]        out_data_reg, out_data_next;
    logic              emit;
    logic [7:0]        byte_val;
    logic [8:0]        data_idx;

    assign tok_pop  = tok_valid && (!out_valid_reg || writes.ready);
    assign byte_val = {high_reg, tok.nibble};
    assign data_idx = index_reg - ihexd_pkg::HDR_BYTES;

    always_comb
    begin
        phase_next = phase_reg;
        if (tok_pop)
        begin
            if (tok.kind == ihexd_pkg::TK_NEWLINE)
            begin
                phase_next = ihexd_pkg::PH_WAIT;
            end
            else
            begin
                case (phase_reg)
                    ihexd_pkg::PH_WAIT:
                    begin
                        phase_next = (tok.kind == ihexd_pkg::TK_COLON) ?
                                     ihexd_pkg::PH_RECORD : ihexd_pkg::PH_SKIP;
                    end
                    ihexd_pkg::PH_RECORD: phase_next = ihexd_pkg::PH_RECORD;
                    default:              phase_next = ihexd_pkg::PH_SKIP;
                endcase
            end
        end
    end

    always_comb
    begin
        have_next     = have_reg;
        high_next     = high_reg;
        index_next    = index_reg;
        length_next   = length_reg;
        address_next  = address_reg;
        kind_next     = kind_reg;
        emit          = 1'b0;
        out_addr_next = out_addr_reg;
        out_data_next = out_data_reg;
        if (tok_pop)
        begin
            if (tok.kind == ihexd_pkg::TK_NEWLINE)
            begin
                have_next = 1'b0;
            end
            else if (phase_reg == ihexd_pkg::PH_WAIT)
            begin
                if (tok.kind == ihexd_pkg::TK_COLON)
                begin
                    have_next  = 1'b0;
                    high_next  = 4'd0;
                    index_next = '0;
                end
            end
            else if (phase_reg == ihexd_pkg::PH_RECORD)
            begin
                if (!have_reg)
                begin
                    high_next = tok.nibble;
                    have_next = 1'b1;
                end
                else
                begin
                    have_next = 1'b0;
                    case (index_reg)
                        ihexd_pkg::IDX_COUNT: length_next = byte_val;
                        ihexd_pkg::IDX_ADDRH: address_next = {byte_val, address_reg[7:0]};
                        ihexd_pkg::IDX_ADDRL: address_next = {address_reg[15:8], byte_val};
                        ihexd_pkg::IDX_KIND:  kind_next = byte_val;
                        default:
                        begin
                            if (kind_reg == ihexd_pkg::KIND_DATA &&
                                data_idx < {1'b0, length_reg})
                            begin
                                emit          = 1'b1;
                                out_addr_next = {1'b0, address_reg} + {8'b0, data_idx};
                                out_data_next = byte_val;
                            end
                        end
                    endcase
                    if (index_reg != ihexd_pkg::INDEX_MAX)
                    begin
                        index_next = index_reg + 9'd1;
                    end
                end
            end
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (writes.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ihexd_pkg::PH_WAIT;
            have_reg      <= 1'b0;
            high_reg      <= 4'd0;
            index_reg     <= '0;
            length_reg    <= '0;
            address_reg   <= '0;
            kind_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            have_reg      <= have_next;
            high_reg      <= high_next;
            index_reg     <= index_next;
            length_reg    <= length_next;
            address_reg   <= address_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_addr_reg <= out_addr_next;
        out_data_reg <= out_data_next;
    end

    assign writes.valid      = out_valid_reg;
    assign writes.write_addr = out_addr_reg;
    assign writes.write_data = out_data_reg;

    `IHEXD_ASSERT(a_emit_from_record, emit |-> (phase_reg == ihexd_pkg::PH_RECORD && have_reg && index_reg >= ihexd_pkg::HDR_BYTES), "write emitted outside a record data byte")
    `IHEXD_ASSERT(a_no_pop_when_blocked, (out_valid_reg && !writes.ready) |-> !tok_pop, "token consumed while output register is blocked")
    `IHEXD_ASSERT(a_newline_resets, (tok_pop && tok.kind == ihexd_pkg::TK_NEWLINE) |=> (phase_reg == ihexd_pkg::PH_WAIT && !have_reg), "newline did not return to line start")

endmodule

// File: hdl/intel_hex_record_decoder_unit.sv
// ----------------------------------------------------------------------------
// Intel HEX record decoder
// Decodes Intel HEX text into data byte writes at linear addresses.
// ----------------------------------------------------------------------------
// channel   role    payload                  accepted when
// chars     sink    char_in[7:0]             chars.valid && chars.ready
// writes    source  write_addr[16:0],        writes.valid && writes.ready
//                   write_data[7:0]
//
// One character per cycle sustained unless stalled; a data byte reaches the
// output register after its second digit passes the token queue and engine.
// The record engine sets throughput: one token per cycle unless stalled.
// A two-entry token queue separates classifier and engine; whitespace is
// dropped before the queue. A stalled output stops the engine, and input
// stalls once the queue fills. Reset clears all control state at once.
// ----------------------------------------------------------------------------
module intel_hex_record_decoder_unit (
    input  logic          clk,
    input  logic          rst_n,
    ihexd_char_if.sink    chars,
    ihexd_write_if.source writes
);

    ihexd_pkg::token_t push_tok;
    ihexd_pkg::token_t pop_tok;
    logic              push;
    logic              full;
    logic              pop;
    logic              not_empty;

    ihexd_front u_front (
        .chars    (chars),
        .full     (full),
        .push     (push),
        .push_tok (push_tok)
    );

    ihexd_token_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_tok  (push_tok),
        .full      (full),
        .pop       (pop),
        .pop_tok   (pop_tok),
        .not_empty (not_empty)
    );

    ihexd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (not_empty),
        .tok       (pop_tok),
        .tok_pop   (pop),
        .writes    (writes)
    );

endmodule

// File: verif/tb_intel_hex_record_decoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Intel HEX record decoder testbench
// Streams directed and random HEX text into the decoder and checks every
// data byte write, in order, against a cycle-free model of the record parser.
// ----------------------------------------------------------------------------
module tb_intel_hex_record_decoder_unit;

    typedef struct {
        logic [16:0] addr;
        logic [7:0]  data;
    } wr_t;

    typedef struct {
        logic [7:0]  ch;
        bit          typed;
        bit          has_wr;
        logic [16:0] addr;
        logic [7:0]  data;
    } dir_row_t;

    localparam int N_DIR = 21;
    localparam int N_ITEMS = 600;

    dir_row_t dir_rows [N_DIR] = '{
        '{8'h00,                 1'b1, 1'b0, 17'h00000, 8'h00},
        '{ihexd_pkg::CHAR_NL,    1'b1, 1'b0, 17'h00000, 8'h00},
        '{8'd32,                 1'b1, 1'b0, 17'h00000, 8'h00},
        '{ihexd_pkg::CHAR_COLON, 1'b0, 1'b0, 17'h00000, 8'h00},
        '{"0",                   1'b0, 1'b0, 17'h00000, 8'h00},
        '{"2",                   1'b0, 1'b0, 17'h00000, 8'h00},
        '{"F",                   1'b0, 1'b0, 17'h00000, 8'h00},
        '{"F",                   1'b0, 1'b0, 17'h00000, 8'h00},
        '{"F",                   1'b0, 1'b0, 17'h00000, 8'h00},
        '{"F",                   1'b0, 1'b0, 17'h00000, 8'h00},
        '{"0",                   1'b0, 1'b0, 17'h00000, 8'h00},
        '{8'd9,                  1'b0, 1'b0, 17'h00000, 8'h00},
        '{"0",                   1'b0, 1'b0, 17'h00000, 8'h00},
        '{"F",                   1'b0, 1'b0, 17'h00000, 8'h00},
        '{"F",                   1'b1, 1'b1, 17'h0FFFF, 8'hFF},
        '{8'hFF,                 1'b0, 1'b0, 17'h00000, 8'h00},
        '{"0",                   1'b1, 1'b1, 17'h10000, 8'h00},
        '{"A",                   1'b0, 1'b0, 17'h00000, 8'h00},
        '{"B",                   1'b0, 1'b0, 17'h00000, 8'h00},
        '{"C",                   1'b0, 1'b0, 17'h00000, 8'h00},
        '{ihexd_pkg::CHAR_NL,    1'b1, 1'b0, 17'h00000, 8'h00}
    };

    logic clk = 1'b0;
    logic rst_n;

    ihexd_char_if  chars_if ();
    ihexd_write_if writes_if ();

    intel_hex_record_decoder_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .writes (writes_if)
    );

    ihexd_pkg::phase_t ln_phase;
    bit          nib_held;
    logic [3:0]  nib_hi;
    logic [8:0]  byte_idx;
    logic [7:0]  rec_len;
    logic [15:0] rec_addr;
    logic [7:0]  rec_kind;

    wr_t         pending_writes [$];
    logic [7:0]  line_buf [$];
    bit          quiet;
    int          sink_wait;
    int          n_err;
    int          n_items;
    int          n_writes;
    int          n_records;
    int          n_other_lines;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void append_char(logic [7:0] c);
        line_buf = {line_buf, c};
    endfunction

    function automatic void queue_write(wr_t w);
        pending_writes = {pending_writes, w};
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == 8'd9 || c == 8'd10 || c == 8'd11 || c == 8'd12 || c == 8'd13 ||
               c == 8'd32;
    endfunction

    function automatic logic [3:0] nibble_of(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 4'(c - "0");
        if (c >= "A" && c <= "F")
            return 4'(c - "A" + 8'd10);
        return 4'd0;
    endfunction

    function automatic bit fold_char(logic [7:0] c, output wr_t w);
        logic [7:0] b;
        logic [8:0] idx;
        bit         hit;
        hit = 1'b0;
        w.addr = '0;
        w.data = '0;
        if (c == ihexd_pkg::CHAR_NL)
        begin
            ln_phase = ihexd_pkg::PH_WAIT;
            nib_held = 1'b0;
            return 1'b0;
        end
        if (ln_phase == ihexd_pkg::PH_WAIT)
        begin
            if (is_blank(c))
                return 1'b0;
            if (c == ihexd_pkg::CHAR_COLON)
            begin
                ln_phase = ihexd_pkg::PH_RECORD;
                nib_held = 1'b0;
                nib_hi = 4'd0;
                byte_idx = '0;
            end
            else
                ln_phase = ihexd_pkg::PH_SKIP;
            return 1'b0;
        end
        if (ln_phase != ihexd_pkg::PH_RECORD || is_blank(c))
            return 1'b0;
        if (!nib_held)
        begin
            nib_hi = nibble_of(c);
            nib_held = 1'b1;
            return 1'b0;
        end
        nib_held = 1'b0;
        b = {nib_hi, nibble_of(c)};
        case (byte_idx)
            ihexd_pkg::IDX_COUNT: rec_len = b;
            ihexd_pkg::IDX_ADDRH: rec_addr[15:8] = b;
            ihexd_pkg::IDX_ADDRL: rec_addr[7:0] = b;
            ihexd_pkg::IDX_KIND:  rec_kind = b;
            default:
            begin
                idx = byte_idx - ihexd_pkg::HDR_BYTES;
                if (rec_kind == ihexd_pkg::KIND_DATA && idx < {1'b0, rec_len})
                begin
                    w.addr = {1'b0, rec_addr} + {8'd0, idx};
                    w.data = b;
                    hit = 1'b1;
                end
            end
        endcase
        if (byte_idx < ihexd_pkg::INDEX_MAX)
            byte_idx = byte_idx + 9'd1;
        return hit;
    endfunction

    function automatic logic [7:0] hex_ascii(logic [3:0] n, bit lower);
        if (n < 4'd10)
            return 8'("0") + 8'(n);
        return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 4))
            0: return 8'd9;
            1: return 8'd11;
            2: return 8'd12;
            3: return 8'd13;
            default: return 8'd32;
        endcase
    endfunction

    function automatic logic [7:0] digit_char(logic [3:0] n, bit messy);
        if (messy && $urandom_range(0, 11) == 0)
            return ($urandom_range(0, 1) == 0) ? hex_ascii(n, 1'b1)
                                               : 8'($urandom_range(0, 255));
        return hex_ascii(n, 1'b0);
    endfunction

    function automatic void put_byte(logic [7:0] b, bit messy);
        if (messy && $urandom_range(0, 7) == 0)
            append_char(blank_char());
        append_char(digit_char(b[7:4], messy));
        if (messy && $urandom_range(0, 9) == 0)
            append_char(blank_char());
        append_char(digit_char(b[3:0], messy));
    endfunction

    task automatic send_char(logic [7:0] c);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars_if.valid   <= 1'b1;
        chars_if.char_in <= c;
        do
            @(posedge clk);
        while (!chars_if.ready);
        n_items++;
    endtask

    task automatic send_predicted(logic [7:0] c);
        wr_t w;
        send_char(c);
        if (fold_char(c, w))
            queue_write(w);
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_predicted(line_buf[i]);
        line_buf.delete();
    endtask

    task automatic drain_writes();
        while (pending_writes.size() != 0)
            @(posedge clk);
    endtask

    task automatic build_record(int cnt, logic [15:0] addr, logic [7:0] kind, int extra,
                                bit messy);
        logic [7:0] sum;
        logic [7:0] d;
        if ($urandom_range(0, 3) == 0)
            append_char(blank_char());
        append_char(ihexd_pkg::CHAR_COLON);
        sum = 8'(cnt) + addr[15:8] + addr[7:0] + kind;
        put_byte(8'(cnt), messy);
        put_byte(addr[15:8], messy);
        put_byte(addr[7:0], messy);
        put_byte(kind, messy);
        for (int i = 0; i < cnt; i++)
        begin
            d = 8'($urandom_range(0, 255));
            sum += d;
            put_byte(d, messy);
        end
        put_byte(8'(-sum), messy);
        for (int i = 0; i < extra; i++)
            put_byte(8'($urandom_range(0, 255)), messy);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        wr_t exp_w;
        int  gap;
        if (!rst_n)
        begin
            writes_if.ready <= 1'b0;
            sink_wait <= 0;
        end
        else
        begin
            if (writes_if.valid && writes_if.ready)
            begin
                n_writes++;
                if (pending_writes.size() == 0)
                begin
                    n_err++;
                    $display("%0t write with none expected: expected none, actual %h/%h",
                             $time, writes_if.write_addr, writes_if.write_data);
                end
                else
                begin
                    exp_w = pending_writes.pop_front();
                    if (writes_if.write_addr !== exp_w.addr)
                    begin
                        n_err++;
                        $display("%0t write_addr mismatch: expected %h, actual %h",
                                 $time, exp_w.addr, writes_if.write_addr);
                    end
                    if (writes_if.write_data !== exp_w.data)
                    begin
                        n_err++;
                        $display("%0t write_data mismatch: expected %h, actual %h",
                                 $time, exp_w.data, writes_if.write_data);
                    end
                end
                gap = quiet ? 0 : $urandom_range(0, 15);
                sink_wait <= gap;
                writes_if.ready <= (gap == 0);
            end
            else if (sink_wait > 1)
            begin
                sink_wait <= sink_wait - 1;
                writes_if.ready <= 1'b0;
            end
            else
            begin
                sink_wait <= 0;
                writes_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("intel_hex_record_decoder_unit verification failed");
        $finish;
    end

    initial
    begin
        wr_t        w;
        bit         hit;
        int         kind_sel;
        int         cnt;
        int         cut;
        logic [15:0] addr;
        logic [7:0] kind;

        rst_n = 1'b0;
        chars_if.valid = 1'b0;
        chars_if.char_in = 8'h00;
        quiet = 1'b0;
        n_items = 0;
        n_records = 0;
        n_other_lines = 0;
        ln_phase = ihexd_pkg::PH_WAIT;
        nib_held = 1'b0;
        nib_hi = 4'd0;
        byte_idx = '0;
        rec_len = '0;
        rec_addr = '0;
        rec_kind = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            send_char(dir_rows[i].ch);
            hit = fold_char(dir_rows[i].ch, w);
            if (dir_rows[i].typed)
            begin
                hit = dir_rows[i].has_wr;
                w.addr = dir_rows[i].addr;
                w.data = dir_rows[i].data;
            end
            if (hit)
                queue_write(w);
        end

        chars_if.valid <= 1'b0;
        drain_writes();

        // long record across the top of memory, then bytes past the checksum
        quiet = 1'b1;
        build_record(64, 16'hFFE0, ihexd_pkg::KIND_DATA, 3, 1'b0);
        append_char(ihexd_pkg::CHAR_NL);
        send_line();
        n_records++;
        quiet = 1'b0;

        while (n_items < N_ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
                quiet = !quiet;
            if ($urandom_range(0, 19) == 0)
            begin
                chars_if.valid <= 1'b0;
                drain_writes();
            end
            kind_sel = $urandom_range(0, 99);
            if (kind_sel < 70)
            begin
                cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32)
                                                  : $urandom_range(0, 8);
                addr = ($urandom_range(0, 7) == 0) ? 16'hFFFF - 16'($urandom_range(0, 8))
                                                   : 16'($urandom_range(0, 65535));
                kind = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
                                                   : ihexd_pkg::KIND_DATA;
                build_record(cnt, addr, kind, ($urandom_range(0, 5) == 0) ? 2 : 0,
                             $urandom_range(0, 3) == 0);
                if ($urandom_range(0, 7) == 0)
                begin
                    cut = $urandom_range(0, line_buf.size() - 1);
                    line_buf = line_buf[0:cut];
                end
                if ($urandom_range(0, 5) == 0)
                    append_char(hex_ascii(4'($urandom_range(0, 15)), 1'b0));
                append_char(ihexd_pkg::CHAR_NL);
                n_records++;
            end
            else if (kind_sel < 85)
            begin
                do
                    append_char(8'($urandom_range(33, 126)));
                while (line_buf[0] == ihexd_pkg::CHAR_COLON &&
                       line_buf.pop_front() == ihexd_pkg::CHAR_COLON);
                for (int i = $urandom_range(0, 10); i > 0; i--)
                    append_char(($urandom_range(0, 2) == 0) ? ihexd_pkg::CHAR_COLON
                                : hex_ascii(4'($urandom_range(0, 15)), 1'b0));
                append_char(ihexd_pkg::CHAR_NL);
                n_other_lines++;
            end
            else
            begin
                for (int i = $urandom_range(1, 12); i > 0; i--)
                    append_char(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) != 0)
                    append_char(ihexd_pkg::CHAR_NL);
                n_other_lines++;
            end
            send_line();
        end

        chars_if.valid <= 1'b0;
        quiet = 1'b0;
        drain_writes();
        repeat (20) @(posedge clk);

        $display("Sent %0d characters in %0d records and %0d other lines;",
                 n_items, n_records, n_other_lines);
        $display("checked %0d data writes, %0d mismatches.", n_writes, n_err);
        if (n_err == 0 && pending_writes.size() == 0)
            $display("intel_hex_record_decoder_unit verification clean");
        else
            $display("intel_hex_record_decoder_unit verification failed");
        $finish;
    end

endmodule
